// ===== src/neighbor_strength_table_unit_defines.svh =====
// Assertion macros for the neighbor strength table unit.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef NEIGHBOR_STRENGTH_TABLE_UNIT_DEFINES_SVH
`define NEIGHBOR_STRENGTH_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NST_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define NST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/nst_pkg.sv =====
// Shared constants, codes and controller/datapath interface types
// for the neighbor strength table. No dependencies.
`default_nettype none

package nst_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int MAX_REPORTS   = 16;
	localparam int IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
	localparam int RPT_LIMIT = (MAX_REPORTS < TABLE_ENTRIES) ? MAX_REPORTS : TABLE_ENTRIES;
	localparam int SUM_W     = 16;
	localparam int SCNT_W    = 8;
	localparam int SAMPLES   = 2;
	localparam int DIV_CW    = $clog2(SUM_W);

	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_RECORD = 2'd1;
	localparam logic [1:0] REQ_DUMP   = 2'd2;

	localparam logic [2:0] ST_ACC    = 3'd0;
	localparam logic [2:0] ST_INS    = 3'd1;
	localparam logic [2:0] ST_FULL   = 3'd2;
	localparam logic [2:0] ST_OVF    = 3'd3;
	localparam logic [2:0] ST_REPORT = 3'd4;
	localparam logic [2:0] ST_EMPTY  = 3'd5;

	typedef struct packed {
		logic capture;
		logic prep;
		logic read;
		logic resolve;
		logic div_step;
		logic dump_next;
	} nst_cmd_t;

	typedef struct packed {
		logic [1:0] req;
		logic       used_zero;
		logic       div_done;
		logic       res_last;
	} nst_stat_t;

	function automatic logic [4:0] total_of(input logic [CNT_W-1:0] u);
		if (int'(u) > 31) return 5'd31;
		return 5'(u);
	endfunction

endpackage

`default_nettype wire

// ===== src/nst_ctrl.sv =====
// Neighbor strength table sequencer: prepare, read, resolve, divide,
// output; clear, empty dump skip read/resolve. Depends on nst_pkg.
`default_nettype none

module nst_ctrl import nst_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire nst_stat_t stat,
	output nst_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_READ,
		S_RESOLVE,
		S_DIV,
		S_OUT
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q    <= S_PREP;
						in_ready_q <= 1'b0;
					end
				end
				S_PREP: begin
					case (stat.req)
						REQ_CLEAR:  state_q <= S_DIV;
						REQ_RECORD: state_q <= S_READ;
						REQ_DUMP:   state_q <= stat.used_zero ? S_DIV : S_READ;
						default: begin
							// unused code: drop the word
							state_q    <= S_IDLE;
							in_ready_q <= 1'b1;
						end
					endcase
				end
				S_READ:    state_q <= S_RESOLVE;
				S_RESOLVE: state_q <= S_DIV;
				S_DIV: begin
					if (stat.div_done) begin
						state_q     <= S_OUT;
						out_valid_q <= 1'b1;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (stat.res_last) begin
							state_q    <= S_IDLE;
							in_ready_q <= 1'b1;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q     <= S_IDLE;
					in_ready_q  <= 1'b1;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.capture   = (state_q == S_IDLE) && in_valid;
		cmd.prep      = (state_q == S_PREP);
		cmd.read      = (state_q == S_READ);
		cmd.resolve   = (state_q == S_RESOLVE);
		cmd.div_step  = (state_q == S_DIV);
		cmd.dump_next = (state_q == S_OUT) && out_ready && !stat.res_last;
	end

endmodule

`default_nettype wire

// ===== src/nst_dp.sv =====
// Datapath for the neighbor strength table: entry storage, parallel
// address match, update checks, serial divider and result registers. Depends on nst_pkg.
`default_nettype none

module nst_dp import nst_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire nst_cmd_t           cmd,
	output nst_stat_t               stat,
	input  wire logic [1:0]         req_type,
	input  wire logic [31:0]        neighbor_addr,
	input  wire logic signed [7:0]  rx_strength,
	input  wire logic signed [7:0]  tx_strength,
	output logic [2:0]              status,
	output logic [31:0]             entry_addr,
	output logic signed [7:0]       mean_strength,
	output logic [4:0]              entry_total,
	output logic                    last
);

	// entry storage, no reset: only slots below the fill count are used
	logic [31:0]       addr_tab [TABLE_ENTRIES];
	logic [SUM_W-1:0]  sum_mem  [TABLE_ENTRIES];
	logic [SCNT_W-1:0] cnt_mem  [TABLE_ENTRIES];

	logic [CNT_W-1:0]  used_q;

	logic [1:0]        req_q;
	logic [31:0]       addr_q;
	logic [7:0]        rx_q;
	logic [7:0]        tx_q;
	logic [IDX_W-1:0]  idx_q;
	logic              hit_q;
	logic [SUM_W-1:0]  rd_sum_q;
	logic [SCNT_W-1:0] rd_cnt_q;
	logic [31:0]       rd_addr_q;

	logic [2:0]        res_status_q;
	logic [31:0]       res_addr_q;
	logic              res_last_q;

	logic [SUM_W-1:0]  dvd_q;
	logic [SCNT_W-1:0] dvs_q;
	logic [SCNT_W-1:0] rem_q;
	logic              neg_q;
	logic [DIV_CW-1:0] div_cnt_q;

	logic              hit;
	logic [IDX_W-1:0]  hit_idx;
	logic [SUM_W-1:0]  pair_sum;
	logic [SUM_W:0]    new_sum;
	logic [SCNT_W:0]   new_cnt;
	logic              ovf;
	logic              can_insert;
	logic [CNT_W-1:0]  dump_n;
	logic              dump_last;

	logic              start_div;
	logic [SUM_W-1:0]  op_sum;
	logic [SCNT_W-1:0] op_cnt;
	logic [2:0]        r_status;
	logic [31:0]       r_addr;
	logic              r_last;
	logic              wr_en;
	logic              ins;
	logic [IDX_W-1:0]  wr_idx;
	logic [SUM_W-1:0]  wr_sum;
	logic [SCNT_W-1:0] wr_cnt;

	logic [SCNT_W:0]   shifted;
	logic [SCNT_W:0]   trial;

	// parallel match over held slots; lowest slot wins
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if ((CNT_W'(i) < used_q) && (addr_tab[i] == addr_q)) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
		end
	end

	assign pair_sum   = {{(SUM_W-8){rx_q[7]}}, rx_q} + {{(SUM_W-8){tx_q[7]}}, tx_q};
	assign new_sum    = {rd_sum_q[SUM_W-1], rd_sum_q} + {pair_sum[SUM_W-1], pair_sum};
	assign new_cnt    = {1'b0, rd_cnt_q} + (SCNT_W+1)'(SAMPLES);
	assign ovf        = new_cnt[SCNT_W] || (new_sum[SUM_W] != new_sum[SUM_W-1]);
	assign can_insert = used_q < CNT_W'(TABLE_ENTRIES);
	assign dump_n     = (used_q > CNT_W'(RPT_LIMIT)) ? CNT_W'(RPT_LIMIT) : used_q;
	assign dump_last  = (CNT_W'(idx_q) + CNT_W'(1)) == dump_n;

	always_comb begin
		start_div = 1'b0;
		op_sum    = '0;
		op_cnt    = SCNT_W'(SAMPLES);
		r_status  = ST_EMPTY;
		r_addr    = '0;
		r_last    = 1'b1;
		wr_en     = 1'b0;
		ins       = 1'b0;
		wr_idx    = idx_q;
		wr_sum    = new_sum[SUM_W-1:0];
		wr_cnt    = new_cnt[SCNT_W-1:0];
		if (cmd.prep) begin
			if ((req_q == REQ_CLEAR) || ((req_q == REQ_DUMP) && (used_q == '0)))
				start_div = 1'b1;
		end
		if (cmd.resolve) begin
			start_div = 1'b1;
			if (req_q == REQ_DUMP) begin
				r_status = ST_REPORT;
				r_addr   = rd_addr_q;
				op_sum   = rd_sum_q;
				op_cnt   = rd_cnt_q;
				r_last   = dump_last;
			end else if (hit_q) begin
				r_addr = addr_q;
				if (ovf) begin
					// refuse update, report current mean
					r_status = ST_OVF;
					op_sum   = rd_sum_q;
					op_cnt   = rd_cnt_q;
				end else begin
					r_status = ST_ACC;
					op_sum   = new_sum[SUM_W-1:0];
					op_cnt   = new_cnt[SCNT_W-1:0];
					wr_en    = 1'b1;
				end
			end else if (can_insert) begin
				r_status = ST_INS;
				r_addr   = addr_q;
				op_sum   = pair_sum;
				wr_en    = 1'b1;
				ins      = 1'b1;
				wr_idx   = IDX_W'(used_q);
				wr_sum   = pair_sum;
				wr_cnt   = SCNT_W'(SAMPLES);
			end else begin
				r_status = ST_FULL;
				r_addr   = addr_q;
			end
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.prep && (req_q == REQ_CLEAR)) begin
			used_q <= '0;
		end else if (ins) begin
			used_q <= used_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			sum_mem[wr_idx] <= wr_sum;
			cnt_mem[wr_idx] <= wr_cnt;
		end
		if (ins)
			addr_tab[wr_idx] <= addr_q;
		if (cmd.read) begin
			rd_sum_q  <= sum_mem[idx_q];
			rd_cnt_q  <= cnt_mem[idx_q];
			rd_addr_q <= addr_tab[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= req_type;
			addr_q <= neighbor_addr;
			rx_q   <= rx_strength;
			tx_q   <= tx_strength;
		end
		if (cmd.prep) begin
			hit_q <= hit;
			idx_q <= (req_q == REQ_DUMP) ? '0 : hit_idx;
		end else if (cmd.dump_next) begin
			idx_q <= idx_q + IDX_W'(1);
		end
		if (start_div) begin
			res_status_q <= r_status;
			res_addr_q   <= r_addr;
			res_last_q   <= r_last;
		end
	end

	// restoring divider on magnitudes, one quotient bit per cycle
	assign shifted = {rem_q, dvd_q[SUM_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (start_div) begin
			dvd_q     <= op_sum[SUM_W-1] ? -op_sum : op_sum;
			neg_q     <= op_sum[SUM_W-1];
			dvs_q     <= op_cnt;
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + DIV_CW'(1);
			if (shifted >= {1'b0, dvs_q}) begin
				rem_q <= trial[SCNT_W-1:0];
				dvd_q <= {dvd_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[SCNT_W-1:0];
				dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	assign stat.req       = req_q;
	assign stat.used_zero = (used_q == '0);
	assign stat.div_done  = (div_cnt_q == DIV_CW'(SUM_W - 1));
	assign stat.res_last  = res_last_q;

	assign status        = res_status_q;
	assign entry_addr    = res_addr_q;
	assign mean_strength = neg_q ? $signed(-dvd_q[7:0]) : $signed(dvd_q[7:0]);
	assign entry_total   = total_of(used_q);
	assign last          = res_last_q;

endmodule

`default_nettype wire

// ===== src/neighbor_strength_table_unit.sv =====
// Neighbor strength table: one word in at a time, results out in order.
// A record passes prepare, read, resolve and the 16-step serial divider for the mean before
// out_valid rises; a clear or an empty dump skips read and resolve; a dump goes back through
// read, resolve and divide for each report. Next word is taken after the last result.
// Reset (arst_n low, asynchronous) empties the table and idles the sequencer.
`default_nettype none
`include "neighbor_strength_table_unit_defines.svh"

module neighbor_strength_table_unit import nst_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         req_type,
	input  wire logic [31:0]        neighbor_addr,
	input  wire logic signed [7:0]  rx_strength,
	input  wire logic signed [7:0]  tx_strength,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              status,
	output logic [31:0]             entry_addr,
	output logic signed [7:0]       mean_strength,
	output logic [4:0]              entry_total,
	output logic                    last
);

	nst_cmd_t  cmd;
	nst_stat_t stat;

	nst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	nst_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.req_type      (req_type),
		.neighbor_addr (neighbor_addr),
		.rx_strength   (rx_strength),
		.tx_strength   (tx_strength),
		.status        (status),
		.entry_addr    (entry_addr),
		.mean_strength (mean_strength),
		.entry_total   (entry_total),
		.last          (last)
	);

	`NST_ASSERT_NOW(a_one_side, in_ready, !out_valid, "input and output open together")
	`NST_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "took two words")
	`NST_ASSERT_NOW(a_total_bound, out_valid, int'(entry_total) <= TABLE_ENTRIES, "total too large")
	`NST_ASSERT_NOW(a_empty_shape, out_valid && (status == ST_EMPTY),
		last && (entry_addr == 32'd0) && (entry_total == 5'd0), "bad empty result")

endmodule

`default_nettype wire

// ===== dv/neighbor_strength_table_unit_tb.sv =====
// Self-checking testbench for the neighbor strength table unit.
// Drives clear, record, dump and unused-code words, predicts every result word, checks them in order.
// Depends on nst_pkg and the neighbor_strength_table_unit RTL only.
module neighbor_strength_table_unit_tb;
	import nst_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 1000;
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_WORDS = 24;

	typedef struct {
		logic [2:0] status;
		logic [31:0] addr;
		logic [7:0] mean;
		logic [4:0] total;
		logic last;
	} report_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] req_type;
	logic [31:0] neighbor_addr;
	logic signed [7:0] rx_strength;
	logic signed [7:0] tx_strength;
	logic out_valid;
	logic out_ready;
	logic [2:0] status;
	logic [31:0] entry_addr;
	logic signed [7:0] mean_strength;
	logic [4:0] entry_total;
	logic last;

	// Predicted table contents
	logic [31:0] nb_addr[TABLE_ENTRIES];
	int nb_sum[TABLE_ENTRIES];
	int nb_cnt[TABLE_ENTRIES];
	int nb_used;

	report_t pending_reports[$];
	int errors;
	int results_checked;
	int words_sent[4];
	int peak_used;
	int idle_cycles;
	bit gaps_on;
	bit valid_up;
	logic [31:0] addr_pool[24];

	neighbor_strength_table_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.neighbor_addr(neighbor_addr),
		.rx_strength(rx_strength),
		.tx_strength(tx_strength),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.entry_addr(entry_addr),
		.mean_strength(mean_strength),
		.entry_total(entry_total),
		.last(last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] mean_of_slot(input int slot);
		if (nb_sum[slot] == 0 || nb_cnt[slot] == 0)
			return 8'd0;
		return 8'(nb_sum[slot] / nb_cnt[slot]);
	endfunction

	function automatic void push_report(input logic [2:0] st, input logic [31:0] addr,
			input logic [7:0] mean, input logic lst);
		report_t r;
		r.status = st;
		r.addr = addr;
		r.mean = mean;
		r.total = (nb_used > 31) ? 5'd31 : 5'(nb_used);
		r.last = lst;
		pending_reports.push_back(r);
	endfunction

	// Apply one accepted word to the predicted table and queue its result words.
	function automatic void update_neighbor_table(input logic [1:0] req, input logic [31:0] addr,
			input logic [7:0] rx, input logic [7:0] tx);
		int ns;
		int nc;
		int n;
		int slot;
		words_sent[req]++;
		case (req)
			REQ_CLEAR: begin
				nb_used = 0;
				push_report(ST_EMPTY, 32'd0, 8'd0, 1'b1);
			end
			REQ_RECORD: begin
				slot = -1;
				for (int i = 0; i < nb_used; i++)
					if (slot < 0 && nb_addr[i] == addr)
						slot = i;
				if (slot >= 0) begin
					ns = nb_sum[slot] + int'($signed(rx)) + int'($signed(tx));
					nc = nb_cnt[slot] + SAMPLES;
					if (nc > 255 || ns > 32767 || ns < -32768) begin
						push_report(ST_OVF, addr, mean_of_slot(slot), 1'b1);
					end else begin
						nb_sum[slot] = ns;
						nb_cnt[slot] = nc;
						push_report(ST_ACC, addr, mean_of_slot(slot), 1'b1);
					end
				end else if (nb_used < TABLE_ENTRIES) begin
					slot = nb_used;
					nb_addr[slot] = addr;
					nb_sum[slot] = int'($signed(rx)) + int'($signed(tx));
					nb_cnt[slot] = SAMPLES;
					nb_used++;
					if (nb_used > peak_used)
						peak_used = nb_used;
					push_report(ST_INS, addr, mean_of_slot(slot), 1'b1);
				end else begin
					push_report(ST_FULL, addr, 8'd0, 1'b1);
				end
			end
			REQ_DUMP: begin
				n = (nb_used > MAX_REPORTS) ? MAX_REPORTS : nb_used;
				if (n == 0)
					push_report(ST_EMPTY, 32'd0, 8'd0, 1'b1);
				for (int i = 0; i < n; i++)
					push_report(ST_REPORT, nb_addr[i], mean_of_slot(i), i == n - 1);
			end
			default: ;
		endcase
	endfunction

	task automatic release_input();
		if (valid_up) begin
			in_valid <= 1'b0;
			valid_up = 1'b0;
		end
	endtask

	task automatic send_word(input logic [1:0] req, input logic [31:0] addr,
			input logic [7:0] rx, input logic [7:0] tx);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			release_input();
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		neighbor_addr <= addr;
		rx_strength <= rx;
		tx_strength <= tx;
		valid_up = 1'b1;
		do @(posedge clk); while (!in_ready);
		update_neighbor_table(req, addr, rx, tx);
	endtask

	// Hold the sender until every predicted word has come back.
	task automatic wait_drained();
		release_input();
		while (pending_reports.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic test_basic_records();
		send_word(REQ_DUMP, 32'hDEAD_BEEF, 8'h7F, 8'h80);
		send_word(REQ_CLEAR, 32'hFFFF_FFFF, 8'h00, 8'h00);
		send_word(REQ_RECORD, 32'h0000_0000, 8'sd127, 8'sd127);
		send_word(REQ_RECORD, 32'hFFFF_FFFF, -8'sd128, -8'sd128);
		send_word(REQ_RECORD, 32'h0000_0000, -8'sd128, -8'sd128);
		send_word(REQ_RECORD, 32'h1234_5678, 8'sd5, -8'sd5);
		// small negative sums: mean truncates toward zero, not down
		send_word(REQ_RECORD, 32'h1234_5678, -8'sd3, 8'sd0);
		send_word(REQ_RECORD, 32'h1234_5678, -8'sd4, 8'sd0);
		send_word(REQ_UNUSED, 32'hA5A5_5A5A, 8'h55, 8'hAA);
		send_word(REQ_DUMP, 32'd0, 8'd0, 8'd0);
		send_word(REQ_CLEAR, 32'd0, 8'd0, 8'd0);
		send_word(REQ_DUMP, 32'd0, 8'd0, 8'd0);
		wait_drained();
	endtask

	task automatic test_table_full();
		logic [31:0] subnet;
		subnet = $urandom;
		send_word(REQ_CLEAR, 32'd0, 8'd0, 8'd0);
		for (int k = 0; k < TABLE_ENTRIES; k++)
			send_word(REQ_RECORD, {subnet[31:8], 8'(k)}, 8'($urandom), 8'($urandom));
		send_word(REQ_RECORD, {subnet[31:8], 8'hFF}, 8'sd10, 8'sd20);
		send_word(REQ_RECORD, {subnet[31:8], 8'd3}, 8'sd100, -8'sd90);
		send_word(REQ_DUMP, 32'd0, 8'd0, 8'd0);
		wait_drained();
	endtask

	// Count reaches 254 after 127 records; the next one overflows it.
	task automatic test_count_overflow();
		logic [31:0] addr;
		addr = $urandom;
		gaps_on = 1'b0;
		send_word(REQ_CLEAR, 32'd0, 8'd0, 8'd0);
		for (int k = 0; k < 128; k++)
			send_word(REQ_RECORD, addr, -8'sd128, -8'sd128);
		gaps_on = 1'b1;
		send_word(REQ_DUMP, 32'd0, 8'd0, 8'd0);
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int r;
		int sent;
		logic [31:0] addr;
		sent = 0;
		for (int k = 0; k < 24; k++)
			addr_pool[k] = (k < 12) ? {24'h0A_01_00, 8'($urandom)} : $urandom;
		while (sent < RANDOM_WORDS) begin
			gaps_on = !(sent >= 8 && sent < 16);
			if (sent == 12)
				wait_drained();
			r = $urandom_range(0, 99);
			addr = ($urandom_range(0, 3) == 0) ? $urandom : addr_pool[$urandom_range(0, 23)];
			if (r < 4) begin
				send_word(REQ_CLEAR, $urandom, 8'($urandom), 8'($urandom));
			end else if (r < 11) begin
				send_word(REQ_DUMP, $urandom, 8'($urandom), 8'($urandom));
			end else if (r < 14) begin
				send_word(REQ_UNUSED, $urandom, 8'($urandom), 8'($urandom));
				continue;
			end else begin
				send_word(REQ_RECORD, addr, 8'($urandom), 8'($urandom));
			end
			sent++;
		end
		gaps_on = 1'b1;
		wait_drained();
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		report_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected result word, expected none, got status %0d addr %0h",
					$time, status, entry_addr);
				errors++;
			end else begin
				exp_r = pending_reports.pop_front();
				check_field("status", 32'(exp_r.status), 32'(status));
				check_field("entry_addr", exp_r.addr, entry_addr);
				check_field("mean_strength", 32'(exp_r.mean), 32'($unsigned(mean_strength)));
				check_field("entry_total", 32'(exp_r.total), 32'(entry_total));
				check_field("last", 32'(exp_r.last), 32'(last));
				results_checked++;
			end
		end
	end

	// Receiver: ready bursts broken by stalls of random length.
	initial begin
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			int stall;
			stall = pick_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: watchdog, no handshake for %0d cycles", $time, IDLE_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		req_type <= REQ_CLEAR;
		neighbor_addr <= 32'd0;
		rx_strength <= 8'd0;
		tx_strength <= 8'd0;
		errors = 0;
		results_checked = 0;
		peak_used = 0;
		nb_used = 0;
		gaps_on = 1'b1;
		valid_up = 1'b0;
		for (int k = 0; k < 4; k++)
			words_sent[k] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_records();
		test_table_full();
		test_count_overflow();
		test_random_traffic();

		release_input();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_reports.size() != 0) begin
			$display("%0t: %0d result words expected, got none", $time, pending_reports.size());
			errors++;
		end
		$display("Sent %0d clear, %0d record, %0d dump and %0d unused-code words.",
			words_sent[REQ_CLEAR], words_sent[REQ_RECORD], words_sent[REQ_DUMP],
			words_sent[REQ_UNUSED]);
		$display("Checked %0d result words; table held up to %0d entries.",
			results_checked, peak_used);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
